@@ rtl/section_header_scanner_assert.svh @@
// Assertion macros shared by the section header scanner modules.
`ifndef SECTION_HEADER_SCANNER_ASSERT_SVH
`define SECTION_HEADER_SCANNER_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define SHS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("section header scanner check failed");

// Check that post holds in the cycle after pre.
`define SHS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("section header scanner check failed");

`endif

@@ rtl/shs_pkg.sv @@
// Types, constants and decode tables of the section header scanner.
package shs_pkg;

  localparam int KEY_MAX_DEFAULT = 64;
  localparam int POS_W           = 24;
  localparam int ID_W            = 8;
  localparam int LOC_W           = 32;
  localparam int SLOTS           = 3;

  localparam logic [POS_W-1:0] LINE_MAX = '1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] VER_OLD = 2'd1;
  localparam logic [1:0] VER_NEW = 2'd2;

  typedef enum logic [3:0] {
    CL_BLANK, CL_LF, CL_CR, CL_LBRACK, CL_RBRACK, CL_OTHER, CL_C, CL_EQ, CL_NUL
  } byte_class_t;

  typedef enum logic [3:0] {
    ST_BOL      = 4'd0,
    ST_SKIP     = 4'd1,
    ST_CR       = 4'd2,
    ST_OPEN     = 4'd3,
    ST_PRE_KEY  = 4'd4,
    ST_KEY      = 4'd5,
    ST_KEY_END  = 4'd6,
    ST_CLOSED   = 4'd7,
    ST_TRAIL    = 4'd8,
    ST_C_SEEN   = 4'd9
  } scan_state_t;

  typedef enum logic [2:0] {
    EV_KEY_CHAR = 3'd0,
    EV_KEY_DONE = 3'd1,
    EV_REC_LEN  = 3'd2,
    EV_SYNTAX   = 3'd3,
    EV_KEY_LONG = 3'd4,
    EV_EOF      = 3'd5
  } ev_kind_t;

  typedef struct packed {
    logic line;
    logic err;
    logic acc;
    logic save;
    logic open;
    logic close;
    logic quit;
    logic mark;
  } action_t;

  // All results of one byte; line and version are common to them.
  typedef struct packed {
    logic [1:0]           count;
    ev_kind_t [SLOTS-1:0] kind;
    logic [7:0]           key_char;
    logic [LOC_W-1:0]     location;
    logic [POS_W-1:0]     length;
    logic [POS_W-1:0]     line;
    logic [1:0]           version;
  } shs_bundle_t;

  function automatic byte_class_t class_of(input logic [7:0] b);
    byte_class_t c;
    unique case (b)
      CH_TAB, CH_VT, CH_FF, CH_SPACE: c = CL_BLANK;
      CH_LF:     c = CL_LF;
      CH_CR:     c = CL_CR;
      CH_LBRACK: c = CL_LBRACK;
      CH_RBRACK: c = CL_RBRACK;
      CH_C:      c = CL_C;
      CH_EQ:     c = CL_EQ;
      CH_NUL:    c = CL_NUL;
      default:   c = CL_OTHER;
    endcase
    return c;
  endfunction

  function automatic scan_state_t next_of(input scan_state_t st, input byte_class_t c);
    scan_state_t nx;
    logic        key_byte;
    nx = ST_SKIP;
    key_byte = (c == CL_OTHER) || (c == CL_C) || (c == CL_EQ);
    unique case (c)
      CL_LF, CL_NUL: nx = ST_BOL;
      CL_CR:         nx = ST_CR;
      default: begin
        unique case (st)
          ST_BOL: begin
            if (c == CL_BLANK) nx = ST_BOL;
            else if (c == CL_LBRACK) nx = ST_OPEN;
            else if (c == CL_C) nx = ST_C_SEEN;
          end
          ST_CR: begin
            if (c == CL_BLANK) nx = ST_BOL;
            else if (c == CL_LBRACK) nx = ST_OPEN;
          end
          ST_OPEN, ST_PRE_KEY: begin
            if (c == CL_BLANK) nx = ST_PRE_KEY;
            else if (key_byte) nx = ST_KEY;
          end
          ST_KEY: begin
            if (c == CL_BLANK) nx = ST_KEY_END;
            else if (c == CL_RBRACK) nx = ST_CLOSED;
            else if (key_byte) nx = ST_KEY;
          end
          ST_KEY_END: begin
            if (c == CL_BLANK) nx = ST_KEY_END;
            else if (c == CL_RBRACK) nx = ST_CLOSED;
          end
          ST_CLOSED, ST_TRAIL: begin
            if (c == CL_BLANK) nx = ST_TRAIL;
          end
          ST_SKIP:   nx = ST_SKIP;
          ST_C_SEEN: nx = ST_SKIP;
          default:   nx = ST_SKIP;
        endcase
      end
    endcase
    return nx;
  endfunction

  function automatic action_t actions_of(input scan_state_t st, input byte_class_t c);
    action_t a;
    logic    in_key;
    logic    closed;
    a = '0;
    in_key = (st == ST_OPEN) || (st == ST_PRE_KEY) || (st == ST_KEY) || (st == ST_KEY_END);
    closed = (st == ST_CLOSED) || (st == ST_TRAIL);
    unique case (c)
      CL_LF: begin
        a.line = (st != ST_CR);
        a.err  = in_key;
        a.save = closed;
      end
      CL_CR: begin
        a.line = 1'b1;
        a.err  = in_key;
        a.save = closed;
      end
      CL_NUL: begin
        a.quit = 1'b1;
        a.err  = in_key || closed;
      end
      CL_LBRACK: begin
        a.open = (st == ST_BOL) || (st == ST_CR);
        a.err  = in_key || closed;
      end
      CL_RBRACK: begin
        a.close = (st == ST_KEY) || (st == ST_KEY_END);
        a.err   = (st == ST_OPEN) || (st == ST_PRE_KEY) || closed;
      end
      CL_OTHER, CL_C, CL_EQ: begin
        a.acc  = (st == ST_OPEN) || (st == ST_PRE_KEY) || (st == ST_KEY);
        a.err  = (st == ST_KEY_END) || closed;
        a.mark = (c == CL_EQ) && (st == ST_C_SEEN);
      end
      CL_BLANK: a = '0;
      default:  a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/shs_scan_core.sv @@
// Scan state machine: classifies a byte, updates counters and builds its results.
module shs_scan_core #(
  parameter int KEY_MAX = shs_pkg::KEY_MAX_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                write_enable,
  input  logic [7:0]          write_data,
  input  logic                item_valid,
  input  logic [7:0]          item_byte,
  input  logic                free,
  output logic                consume,
  output logic                load,
  output shs_pkg::shs_bundle_t bundle
);
  import shs_pkg::*;

  localparam int KL_W = $clog2(KEY_MAX);
  localparam logic [KL_W-1:0] KEY_LAST = KL_W'(KEY_MAX - 1);

  logic [ID_W-1:0]  file_id;
  scan_state_t      scan_state, scan_state_next;
  logic [KL_W-1:0]  key_length, key_length_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] record_start, record_start_next;
  logic             record_open, record_open_next;
  logic [POS_W-1:0] line_number, line_number_next;
  logic             old_syntax, old_syntax_next;

  byte_class_t      cls;
  action_t          act;
  scan_state_t      go;
  logic             key_full;
  logic             acc_long;
  logic             len_ev;
  logic [POS_W-1:0] rec_len;
  logic             eof_clear;

  assign cls      = class_of(item_byte);
  assign act      = actions_of(scan_state, cls);
  assign go       = next_of(scan_state, cls);
  assign key_full = (key_length == KEY_LAST);
  assign acc_long = act.acc && key_full;
  assign len_ev   = (act.open || act.quit) && record_open;
  assign rec_len  = byte_position - record_start;
  assign consume  = item_valid && free;

  assign eof_clear = (byte_position == '0) && (line_number == POS_W'(1)) &&
                     (scan_state == ST_BOL) && !record_open;

  // Next state
  always_comb begin
    scan_state_next    = scan_state;
    key_length_next    = key_length;
    byte_position_next = byte_position;
    record_start_next  = record_start;
    record_open_next   = record_open;
    line_number_next   = line_number;
    old_syntax_next    = old_syntax;
    if (consume) begin
      if (act.quit) begin
        // end of file: start over for the next file
        scan_state_next    = ST_BOL;
        key_length_next    = '0;
        byte_position_next = '0;
        record_start_next  = '0;
        record_open_next   = 1'b0;
        line_number_next   = POS_W'(1);
        old_syntax_next    = 1'b0;
      end else begin
        scan_state_next = acc_long ? ST_SKIP : go;
        if (act.open) begin
          key_length_next = '0;
        end else if (act.acc && !key_full) begin
          key_length_next = key_length + 1'b1;
        end
        if (act.close) begin
          record_start_next = byte_position + 1'b1;
        end
        if (act.save) begin
          record_open_next = 1'b1;
        end
        if (act.line && line_number != LINE_MAX) begin
          line_number_next = line_number + 1'b1;
        end
        if (act.mark) begin
          old_syntax_next = 1'b1;
        end
        byte_position_next = byte_position + 1'b1;
      end
    end
  end

  // Results of the current byte, packed in emission order
  always_comb begin
    logic [1:0] cnt;
    logic [4:0] cand_valid;
    ev_kind_t   cand_kind [5];
    cnt = '0;
    cand_valid = {act.quit, len_ev, act.acc, act.save, act.err};
    cand_kind[0] = EV_SYNTAX;
    cand_kind[1] = EV_KEY_DONE;
    cand_kind[2] = acc_long ? EV_KEY_LONG : EV_KEY_CHAR;
    cand_kind[3] = EV_REC_LEN;
    cand_kind[4] = EV_EOF;
    for (int j = 0; j < SLOTS; j++) begin
      bundle.kind[j] = EV_KEY_CHAR;
    end
    for (int i = 0; i < 5; i++) begin
      if (cand_valid[i] && cnt != 2'd3) begin
        bundle.kind[cnt] = cand_kind[i];
        cnt = cnt + 1'b1;
      end
    end
    bundle.count    = cnt;
    bundle.key_char = item_byte;
    bundle.location = {file_id, record_start};
    bundle.length   = rec_len;
    bundle.line     = line_number;
    bundle.version  = old_syntax ? VER_OLD : VER_NEW;
    load = consume && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_id       <= '0;
      scan_state    <= ST_BOL;
      key_length    <= '0;
      byte_position <= '0;
      record_start  <= '0;
      record_open   <= 1'b0;
      line_number   <= POS_W'(1);
      old_syntax    <= 1'b0;
    end else begin
      if (write_enable) begin
        file_id <= write_data;
      end
      scan_state    <= scan_state_next;
      key_length    <= key_length_next;
      byte_position <= byte_position_next;
      record_start  <= record_start_next;
      record_open   <= record_open_next;
      line_number   <= line_number_next;
      old_syntax    <= old_syntax_next;
    end
  end

`include "section_header_scanner_assert.svh"

  `SHS_ASSERT_IMP(a_key_length_max, 1'b1, key_length <= KEY_LAST)
  `SHS_ASSERT_IMP(a_line_nonzero, 1'b1, line_number != '0)
  `SHS_ASSERT_NXT(a_eof_restart, consume && act.quit, eof_clear)

endmodule

@@ rtl/shs_result_buf.sv @@
// Result register: holds a byte's results; sends one per cycle unless stalled.
module shs_result_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  shs_pkg::shs_bundle_t bundle,
  input  logic                 event_stall,
  output logic                 free,
  output logic                 event_valid,
  output logic [2:0]           event_kind,
  output logic [7:0]           key_char,
  output logic [31:0]          record_location,
  output logic [23:0]          record_length,
  output logic [23:0]          line_count,
  output logic [1:0]           syntax_version,
  output logic                 last_of_run
);
  import shs_pkg::*;

  shs_bundle_t held;
  logic        valid;
  logic [1:0]  idx;
  logic        last;
  logic        accept;
  ev_kind_t    cur_kind;

  assign cur_kind = held.kind[idx];
  assign last     = (idx == held.count - 2'd1);
  assign accept   = valid && !event_stall;
  assign free     = !valid || (accept && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (accept) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  assign event_valid     = valid;
  assign event_kind      = cur_kind;
  assign key_char        = (cur_kind == EV_KEY_CHAR) ? held.key_char : '0;
  assign record_location = (cur_kind == EV_KEY_DONE) ? held.location : '0;
  assign record_length   = (cur_kind == EV_REC_LEN) ? held.length : '0;
  assign line_count      = held.line;
  assign syntax_version  = held.version;
  assign last_of_run     = last;

`include "section_header_scanner_assert.svh"

  `SHS_ASSERT_IMP(a_no_overwrite, load, free)
  `SHS_ASSERT_IMP(a_idx_in_range, valid, (idx < held.count) && (held.count != 2'd0))
  `SHS_ASSERT_NXT(a_hold_on_stall, valid && event_stall, valid && $stable(idx))

endmodule

@@ rtl/section_header_scanner.sv @@
// Section header scanner: byte input register, scan core and result register.
//
// Input channel: data_valid / data_stall carry one file byte per item in
// data_byte; a zero byte ends the file. Output channel: event_valid /
// event_stall carry one result per item. A byte gives zero to three results;
// last_of_run marks the final one of each byte.
// write_enable loads file_id from write_data; write it only while idle.
// A taken byte waits in the input register until the result register is free.
// Throughput: one byte per cycle while bytes give at most one result each and
// event_stall is low. The result register sends one result per cycle while
// event_stall is low, so a byte with more results holds the input register
// until its last result is sent.
// Reset clears the scan state (line 1, offset 0), file_id and both channels.
// When the receiver stalls, the held result stays; the input register then
// fills and data_stall rises until the result register frees up.
module section_header_scanner #(
  parameter int KEY_MAX = shs_pkg::KEY_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [7:0]  write_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  event_kind,
  output logic [7:0]  key_char,
  output logic [31:0] record_location,
  output logic [23:0] record_length,
  output logic [23:0] line_count,
  output logic [1:0]  syntax_version,
  output logic        last_of_run
);
  import shs_pkg::*;

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        consume;
  logic        load;
  logic        free;
  shs_bundle_t bundle;

  assign data_stall = item_valid && !consume;

  // Input register: refill in the same cycle it is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      item_byte <= data_byte;
    end
  end

  shs_scan_core #(
    .KEY_MAX(KEY_MAX)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .free         (free),
    .consume      (consume),
    .load         (load),
    .bundle       (bundle)
  );

  shs_result_buf u_buf (
    .clk             (clk),
    .rst             (rst),
    .load            (load),
    .bundle          (bundle),
    .event_stall     (event_stall),
    .free            (free),
    .event_valid     (event_valid),
    .event_kind      (event_kind),
    .key_char        (key_char),
    .record_location (record_location),
    .record_length   (record_length),
    .line_count      (line_count),
    .syntax_version  (syntax_version),
    .last_of_run     (last_of_run)
  );

endmodule

@@ tb/section_header_scanner_tb.sv @@
// Testbench for the section header scanner: byte driver, result monitor and scan predictor.
`timescale 1ns / 100ps

module section_header_scanner_tb;
  import shs_pkg::*;

  localparam int KEY_LIMIT      = KEY_MAX_DEFAULT;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  ch;
    logic [31:0] loc;
    logic [23:0] len;
    logic [23:0] line_no;
    logic [1:0]  ver;
    logic        last;
  } scan_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        write_enable = 1'b0;
  logic [7:0]  write_data = '0;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = '0;
  logic        event_valid;
  logic        event_stall = 1'b0;
  logic [2:0]  event_kind;
  logic [7:0]  key_char;
  logic [31:0] record_location;
  logic [23:0] record_length;
  logic [23:0] line_count;
  logic [1:0]  syntax_version;
  logic        last_of_run;

  logic [7:0]  pending_bytes[$];
  scan_event_t expected_events[$];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Predictor state
  scan_state_t scan_st;
  logic [6:0]  key_len;
  logic [23:0] byte_pos;
  logic [23:0] rec_start;
  logic        rec_open;
  logic [23:0] cur_line;
  logic        old_syntax;
  logic [7:0]  file_id_m = '0;

  section_header_scanner i_dut (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .write_data      (write_data),
    .data_valid      (data_valid),
    .data_stall      (data_stall),
    .data_byte       (data_byte),
    .event_valid     (event_valid),
    .event_stall     (event_stall),
    .event_kind      (event_kind),
    .key_char        (key_char),
    .record_location (record_location),
    .record_length   (record_length),
    .line_count      (line_count),
    .syntax_version  (syntax_version),
    .last_of_run     (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b)
      CH_TAB, CH_VT, CH_FF, CH_SPACE: c = CL_BLANK;
      CH_LF:     c = CL_LF;
      CH_CR:     c = CL_CR;
      CH_LBRACK: c = CL_LBRACK;
      CH_RBRACK: c = CL_RBRACK;
      CH_C:      c = CL_C;
      CH_EQ:     c = CL_EQ;
      CH_NUL:    c = CL_NUL;
      default:   c = CL_OTHER;
    endcase
    return c;
  endfunction

  task automatic restart_file();
    scan_st    = ST_BOL;
    key_len    = '0;
    byte_pos   = '0;
    rec_start  = '0;
    rec_open   = 1'b0;
    cur_line   = 24'd1;
    old_syntax = 1'b0;
  endtask

  function automatic scan_event_t make_event(input ev_kind_t k, input logic [7:0] ch,
                                             input logic [31:0] loc, input logic [23:0] len);
    scan_event_t e;
    e.kind    = k;
    e.ch      = ch;
    e.loc     = loc;
    e.len     = len;
    e.line_no = cur_line;
    e.ver     = old_syntax ? VER_OLD : VER_NEW;
    e.last    = 1'b0;
    return e;
  endfunction

  // Advance the scan by one accepted byte and queue the results it causes.
  task automatic scan_byte(input logic [7:0] b);
    byte_class_t c;
    scan_state_t st;
    scan_state_t nx;
    logic        opening, keyish, in_key, closed, key_byte, line_end;
    logic        f_err, f_save, f_acc, f_open, f_close, f_mark;
    logic [23:0] rec_len;
    scan_event_t ev[3];
    int          n;
    c        = classify(b);
    st       = scan_st;
    opening  = (st == ST_OPEN) || (st == ST_PRE_KEY);
    keyish   = opening || (st == ST_KEY);
    in_key   = keyish || (st == ST_KEY_END);
    closed   = (st == ST_CLOSED) || (st == ST_TRAIL);
    key_byte = (c == CL_OTHER) || (c == CL_C) || (c == CL_EQ);
    line_end = (c == CL_LF) || (c == CL_CR);
    rec_len  = byte_pos - rec_start;
    n        = 0;

    case (c)
      CL_LF, CL_NUL: nx = ST_BOL;
      CL_CR:         nx = ST_CR;
      CL_BLANK: begin
        case (st)
          ST_BOL, ST_CR:        nx = ST_BOL;
          ST_OPEN, ST_PRE_KEY:  nx = ST_PRE_KEY;
          ST_KEY, ST_KEY_END:   nx = ST_KEY_END;
          ST_CLOSED, ST_TRAIL:  nx = ST_TRAIL;
          default:              nx = ST_SKIP;
        endcase
      end
      CL_LBRACK: nx = (st == ST_BOL || st == ST_CR) ? ST_OPEN : ST_SKIP;
      CL_RBRACK: nx = (st == ST_KEY || st == ST_KEY_END) ? ST_CLOSED : ST_SKIP;
      default: begin
        if (keyish) nx = ST_KEY;
        else if (c == CL_C && st == ST_BOL) nx = ST_C_SEEN;
        else nx = ST_SKIP;
      end
    endcase

    case (c)
      CL_LF, CL_CR:          f_err = in_key;
      CL_NUL, CL_LBRACK:     f_err = in_key || closed;
      CL_RBRACK:             f_err = opening || closed;
      CL_BLANK:              f_err = 1'b0;
      default:               f_err = (st == ST_KEY_END) || closed;
    endcase
    f_save  = line_end && closed;
    f_acc   = key_byte && keyish;
    f_open  = (c == CL_LBRACK) && (st == ST_BOL || st == ST_CR);
    f_close = (c == CL_RBRACK) && (st == ST_KEY || st == ST_KEY_END);
    f_mark  = (c == CL_EQ) && (st == ST_C_SEEN);

    if (f_err) begin
      ev[n] = make_event(EV_SYNTAX, '0, '0, '0);
      n++;
    end
    if (f_save) begin
      ev[n] = make_event(EV_KEY_DONE, '0, {file_id_m, rec_start}, '0);
      n++;
      rec_open = 1'b1;
    end
    if (f_acc) begin
      if (key_len >= KEY_LIMIT - 1) begin
        ev[n] = make_event(EV_KEY_LONG, '0, '0, '0);
        nx = ST_SKIP;
      end else begin
        ev[n] = make_event(EV_KEY_CHAR, b, '0, '0);
        key_len = key_len + 7'd1;
      end
      n++;
    end
    if (f_open) begin
      key_len = '0;
      if (rec_open) begin
        ev[n] = make_event(EV_REC_LEN, '0, '0, rec_len);
        n++;
      end
    end
    if (f_close) rec_start = byte_pos + 24'd1;

    if (c == CL_NUL) begin
      if (rec_open) begin
        ev[n] = make_event(EV_REC_LEN, '0, '0, rec_len);
        n++;
      end
      ev[n] = make_event(EV_EOF, '0, '0, '0);
      n++;
      restart_file();
    end else begin
      if (((c == CL_LF && st != ST_CR) || c == CL_CR) && cur_line != LINE_MAX)
        cur_line = cur_line + 24'd1;
      if (f_mark) old_syntax = 1'b1;
      byte_pos = byte_pos + 24'd1;
      scan_st  = nx;
    end

    if (n > 0) ev[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_events.push_back(ev[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic logic [7:0] rand_blank();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = CH_TAB;
      1:       b = CH_VT;
      2:       b = CH_FF;
      default: b = CH_SPACE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_key_char();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0:       b = CH_C;
      1:       b = CH_EQ;
      default: begin
        do b = 8'($urandom_range(1, 255));
        while (classify(b) != CL_OTHER);
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_LF || b == CH_CR);
    return b;
  endfunction

  // Queue one header line; a broken one gets a random byte somewhere.
  task automatic add_header(input int n_key, input bit broken);
    logic [7:0] q[$];
    q.push_back(CH_LBRACK);
    repeat ($urandom_range(0, 1)) q.push_back(rand_blank());
    repeat (n_key) q.push_back(rand_key_char());
    repeat ($urandom_range(0, 1)) q.push_back(rand_blank());
    q.push_back(CH_RBRACK);
    repeat ($urandom_range(0, 1)) q.push_back(rand_blank());
    case ($urandom_range(0, 2))
      0: q.push_back(CH_LF);
      1: begin
        q.push_back(CH_CR);
        q.push_back(CH_LF);
      end
      default: q.push_back(CH_CR);
    endcase
    if (broken) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(1, 255));
    foreach (q[i]) pending_bytes.push_back(q[i]);
  endtask

  task automatic add_line();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: add_header($urandom_range(1, 8), 1'b0);
      5, 6: begin
        repeat ($urandom_range(0, 10)) pending_bytes.push_back(rand_text_char());
        pending_bytes.push_back(CH_LF);
      end
      7: begin
        pending_bytes.push_back(CH_C);
        pending_bytes.push_back(($urandom_range(0, 3) != 0) ? CH_EQ : rand_text_char());
        pending_bytes.push_back(CH_LF);
      end
      8: repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(1, 255)));
      default: add_header($urandom_range(1, 8), 1'b1);
    endcase
    if ($urandom_range(0, 11) == 0) pending_bytes.push_back(CH_NUL);
  endtask

  task automatic queue_lines(input int n_items);
    int target;
    target = pending_bytes.size() + n_items;
    while (pending_bytes.size() < target) add_line();
  endtask

  // Wait until every byte is taken and every result has arrived, then let the block settle.
  task automatic drain();
    while (pending_bytes.size() != 0 || data_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_file_id(input logic [7:0] id);
    @(posedge clk);
    write_enable <= 1'b1;
    write_data   <= id;
    file_id_m     = id;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      if (data_valid && !data_stall) scan_byte(data_byte);
      if (!data_valid || !data_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          data_valid <= 1'b1;
          data_byte  <= pending_bytes.pop_front();
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : event_check
    scan_event_t e;
    if (rst) begin
      event_stall <= 1'b0;
    end else begin
      event_stall <= ($urandom_range(0, 99) < recv_idle);
      if (event_valid && !event_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result, kind %0d", event_kind));
        end else begin
          e = expected_events.pop_front();
          if (event_kind !== e.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, e.kind));
          if (key_char !== e.ch)
            report_mismatch($sformatf("key_char %h, want %h", key_char, e.ch));
          if (record_location !== e.loc)
            report_mismatch($sformatf("record_location %h, want %h", record_location, e.loc));
          if (record_length !== e.len)
            report_mismatch($sformatf("record_length %0d, want %0d", record_length, e.len));
          if (line_count !== e.line_no)
            report_mismatch($sformatf("line_count %0d, want %0d", line_count, e.line_no));
          if (syntax_version !== e.ver)
            report_mismatch($sformatf("syntax_version %0d, want %0d", syntax_version, e.ver));
          if (last_of_run !== e.last)
            report_mismatch($sformatf("last_of_run %b, want %b", last_of_run, e.last));
        end
      end
    end
  end

  // Count cycles where neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (event_valid && !event_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** section_header_scanner: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    string directed;
    restart_file();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Old syntax marker, record length suppressed before the first key, CR LF ending,
    // tab, VT and FF blanks, bytes at both ends of the range, errors and end of file.
    write_file_id(8'hFF);
    directed = "c=\n[\tk]\n[c=\377]\013\r\n[]x\014";
    for (int i = 0; i < directed.len(); i++) pending_bytes.push_back(directed[i]);
    pending_bytes.push_back(CH_NUL);
    drain();

    write_file_id(8'h00);
    send_idle = 36;
    recv_idle = 66;
    add_header($urandom_range(64, 65), 1'b0);
    queue_lines(5);
    drain();

    write_file_id(8'($urandom_range(1, 254)));
    send_idle = 66;
    recv_idle = 36;
    queue_lines(18);
    drain();

    write_file_id(8'($urandom_range(0, 255)));
    send_idle = 0;
    recv_idle = 0;
    queue_lines(18);
    drain();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("** section_header_scanner: PASSED **");
    end else begin
      $display("** section_header_scanner: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/shs_pkg.sv
rtl/shs_scan_core.sv
rtl/shs_result_buf.sv
rtl/section_header_scanner.sv
tb/section_header_scanner_tb.sv
